// ===== sv/assert_macros.svh =====
// Assertion macros for the checker of the stochastic oscillator.
// Depends on nothing; included by the files that assert.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Concurrent assertion sampled on a clock and switched off while reset is low.
`define SO_ASSERT(label, clk, rstn, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rstn) prop) else $error(msg);

// Concurrent assertion that also holds during reset.
`define SO_ASSERT_ALWAYS(label, clk, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ===== sv/so_pkg.sv =====
// Package of the stochastic oscillator: widths, register codes, result types.
// Depends on nothing; used by every module of the block.
package so_pkg;

  localparam int MAX_WINDOW_DEF = 32;
  localparam int PRICE_BITS_DEF = 32;
  localparam int QUEUE_DEPTH    = 2;
  localparam int LEN_W          = 6;
  localparam int K_W            = 15;
  localparam int ADDR_W         = 4;
  localparam int DATA_W         = 32;
  localparam int SUM_W          = K_W + LEN_W;

  localparam logic [K_W-1:0]   FULL_SCALE     = 15'd25600;
  localparam logic [LEN_W-1:0] WINDOW_LEN_RST = 6'd14;
  localparam logic [LEN_W-1:0] SMOOTH_LEN_RST = 6'd3;
  localparam logic [LEN_W-1:0] SIGNAL_LEN_RST = 6'd3;

  typedef enum logic [1:0] {
    REG_WINDOW = 2'd0,
    REG_SMOOTH = 2'd1,
    REG_SIGNAL = 2'd2
  } reg_idx_e;

  typedef struct packed {
    logic [LEN_W-1:0] window_len;
    logic [LEN_W-1:0] smooth_len;
    logic [LEN_W-1:0] signal_len;
  } cfg_t;

  typedef struct packed {
    logic [K_W-1:0] raw_k;
    logic [K_W-1:0] slow_k;
    logic [K_W-1:0] signal_d;
    logic           slow_valid;
    logic           signal_valid;
    logic           flat_range;
  } res_t;

endpackage

// ===== sv/stochastic_oscillator.sv =====
// A bar passes from the input queue through the back end, which scans the
// ring memories over the effective window, smoothing and signal lengths and
// runs the bit-serial divider. One bar is in the back end at a time, so the
// next bar starts only after the previous one has reached ST_OUT; the scans
// and the divider set the pace. Reset is asynchronous and active low;
// it empties both queues, clears fills and pointers and loads 14, 3 and 3.
module stochastic_oscillator #(
  parameter int MAX_WINDOW = so_pkg::MAX_WINDOW_DEF,
  parameter int PRICE_BITS = so_pkg::PRICE_BITS_DEF
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  // Configuration port
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [so_pkg::ADDR_W-1:0]   paddr,
  input  logic [so_pkg::DATA_W-1:0]   pwdata,
  output logic [so_pkg::DATA_W-1:0]   prdata,
  output logic                        pready,
  // Bar input
  input  logic                        push,
  output logic                        full,
  input  logic [PRICE_BITS-1:0]       high_price_i,
  input  logic [PRICE_BITS-1:0]       low_price_i,
  input  logic [PRICE_BITS-1:0]       close_price_i,
  // Result output
  output logic                        empty,
  input  logic                        pop,
  output logic [so_pkg::K_W-1:0]      raw_k_o,
  output logic [so_pkg::K_W-1:0]      slow_k_o,
  output logic [so_pkg::K_W-1:0]      signal_d_o,
  output logic                        slow_valid_o,
  output logic                        signal_valid_o,
  output logic                        flat_range_o
);
  import so_pkg::*;

  localparam int ITEM_W = 3 * PRICE_BITS;

  cfg_t                  cfg_q;
  logic                  cfg_wr;
  logic [ITEM_W-1:0]     in_data;
  logic                  in_empty, in_pop;
  logic                  out_full, out_push;
  res_t                  res_new, res_head;

  // Registers are written at the access phase of an APB transaction; the
  // port never inserts wait states.
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= '{window_len: WINDOW_LEN_RST, smooth_len: SMOOTH_LEN_RST,
                 signal_len: SIGNAL_LEN_RST};
    end else if (cfg_wr) begin
      case (reg_idx_e'(paddr[3:2]))
        REG_WINDOW: cfg_q.window_len <= pwdata[LEN_W-1:0];
        REG_SMOOTH: cfg_q.smooth_len <= pwdata[LEN_W-1:0];
        REG_SIGNAL: cfg_q.signal_len <= pwdata[LEN_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (reg_idx_e'(paddr[3:2]))
      REG_WINDOW: prdata = DATA_W'(cfg_q.window_len);
      REG_SMOOTH: prdata = DATA_W'(cfg_q.smooth_len);
      REG_SIGNAL: prdata = DATA_W'(cfg_q.signal_len);
      default:    prdata = '0;
    endcase
  end

  // Front end: bars are queued so that a new transaction can be taken while
  // the back end is still busy with the previous one.
  so_fifo #(.W(ITEM_W)) u_in_q (
    .clk_i,
    .rst_ni,
    .push_i  (push),
    .wdata_i ({high_price_i, low_price_i, close_price_i}),
    .full_o  (full),
    .pop_i   (in_pop),
    .rdata_o (in_data),
    .empty_o (in_empty)
  );

  // Back end: ring memories, range scan, ratio and both moving averages.
  so_back #(.MAX_WINDOW(MAX_WINDOW), .PRICE_BITS(PRICE_BITS)) u_back (
    .clk_i,
    .rst_ni,
    .cfg_i      (cfg_q),
    .in_empty_i (in_empty),
    .in_pop_o   (in_pop),
    .high_i     (in_data[3*PRICE_BITS-1:2*PRICE_BITS]),
    .low_i      (in_data[2*PRICE_BITS-1:PRICE_BITS]),
    .close_i    (in_data[PRICE_BITS-1:0]),
    .out_full_i (out_full),
    .out_push_o (out_push),
    .res_o      (res_new)
  );

  // Result queue: a finished result waits here without holding up the back
  // end, which only starts a bar when there is room for its result.
  so_fifo #(.W($bits(res_t))) u_out_q (
    .clk_i,
    .rst_ni,
    .push_i  (out_push),
    .wdata_i (res_new),
    .full_o  (out_full),
    .pop_i   (pop),
    .rdata_o (res_head),
    .empty_o (empty)
  );

  assign raw_k_o        = res_head.raw_k;
  assign slow_k_o       = res_head.slow_k;
  assign signal_d_o     = res_head.signal_d;
  assign slow_valid_o   = res_head.slow_valid;
  assign signal_valid_o = res_head.signal_valid;
  assign flat_range_o   = res_head.flat_range;

endmodule

// ===== sv/so_fifo.sv =====
// Small register queue used on the input and on the result side.
// Depends on so_pkg for the default depth.
module so_fifo #(
  parameter int W     = 8,
  parameter int DEPTH = so_pkg::QUEUE_DEPTH
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         push_i,
  input  logic [W-1:0] wdata_i,
  output logic         full_o,
  input  logic         pop_i,
  output logic [W-1:0] rdata_o,
  output logic         empty_o
);
  import so_pkg::*;

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  logic [W-1:0]     mem_q [DEPTH];
  logic [PTR_W-1:0] wr_ptr_q, rd_ptr_q;
  logic [CNT_W-1:0] cnt_q;
  logic             do_push, do_pop;

  assign full_o  = (cnt_q == CNT_W'(DEPTH));
  assign empty_o = (cnt_q == '0);
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;
  assign rdata_o = mem_q[rd_ptr_q];

  function automatic logic [PTR_W-1:0] next_ptr(input logic [PTR_W-1:0] p);
    return (p == PTR_W'(DEPTH - 1)) ? '0 : p + 1'b1;
  endfunction

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_q <= next_ptr(wr_ptr_q);
      end
      if (do_pop) begin
        rd_ptr_q <= next_ptr(rd_ptr_q);
      end
      if (do_push && !do_pop) begin
        cnt_q <= cnt_q + 1'b1;
      end else if (do_pop && !do_push) begin
        cnt_q <= cnt_q - 1'b1;
      end
    end
  end

endmodule

// ===== sv/so_div.sv =====
// Restoring divider, one quotient bit per cycle.
// Depends on so_pkg; used by the back end for the ratio and the averages.
module so_div #(
  parameter int RW = 32,
  parameter int QW = 15
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          start_i,
  input  logic [RW-1:0] init_rem_i,
  input  logic [QW-1:0] dividend_lo_i,
  input  logic [RW-1:0] divisor_i,
  output logic          done_o,
  output logic [QW-1:0] quot_o
);
  import so_pkg::*;

  localparam int CNT_W = $clog2(QW + 1);

  logic [RW-1:0]    rem_q, div_q;
  logic [QW-1:0]    lo_q, quot_q;
  logic [CNT_W-1:0] cnt_q;
  logic             busy_q, done_q;
  logic [RW:0]      trial;
  logic             fits;

  // The remainder always stays below the divisor, so it keeps RW bits.
  assign trial  = {rem_q, lo_q[QW-1]};
  assign fits   = (trial >= {1'b0, div_q});
  assign done_o = done_q;
  assign quot_o = quot_q;

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      rem_q  <= init_rem_i;
      lo_q   <= dividend_lo_i;
      div_q  <= divisor_i;
      quot_q <= '0;
    end else if (busy_q) begin
      rem_q  <= fits ? RW'(trial - {1'b0, div_q}) : RW'(trial);
      lo_q   <= lo_q << 1;
      quot_q <= {quot_q[QW-2:0], fits};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= busy_q && (cnt_q == CNT_W'(1));
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= CNT_W'(QW);
      end else if (busy_q) begin
        cnt_q <= cnt_q - 1'b1;
        if (cnt_q == CNT_W'(1)) begin
          busy_q <= 1'b0;
        end
      end
    end
  end

endmodule

// ===== sv/so_back.sv =====
// Back end of the oscillator: window rings, range scan, ratio and averages.
// Depends on so_pkg and so_div.
module so_back #(
  parameter int MAX_WINDOW = so_pkg::MAX_WINDOW_DEF,
  parameter int PRICE_BITS = so_pkg::PRICE_BITS_DEF
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  so_pkg::cfg_t          cfg_i,
  input  logic                  in_empty_i,
  output logic                  in_pop_o,
  input  logic [PRICE_BITS-1:0] high_i,
  input  logic [PRICE_BITS-1:0] low_i,
  input  logic [PRICE_BITS-1:0] close_i,
  input  logic                  out_full_i,
  output logic                  out_push_o,
  output so_pkg::res_t          res_o
);
  import so_pkg::*;

  localparam int PTR_W  = $clog2(MAX_WINDOW);
  localparam int FILL_W = $clog2(MAX_WINDOW + 1);
  localparam int PROD_W = PRICE_BITS + K_W;
  localparam int AQ_W   = SUM_W + 1;

  typedef enum logic [3:0] {
    ST_IDLE, ST_SCAN, ST_RATIO, ST_MUL, ST_DIVR, ST_RAWWR, ST_SUMK,
    ST_KGO, ST_DIVK, ST_SLOWWR, ST_SUMD, ST_DGO, ST_DIVD, ST_OUT
  } state_e;

  state_e state_q;

  logic [PRICE_BITS-1:0] high_mem [MAX_WINDOW];
  logic [PRICE_BITS-1:0] low_mem  [MAX_WINDOW];
  logic [K_W-1:0]        raw_mem  [MAX_WINDOW];
  logic [K_W-1:0]        slow_mem [MAX_WINDOW];
  logic [PRICE_BITS-1:0] high_rd_q, low_rd_q;
  logic [K_W-1:0]        raw_rd_q, slow_rd_q;

  logic [PTR_W-1:0]      wp_q, item_ptr_q, slow_ptr_q, rd_addr_q;
  logic [FILL_W-1:0]     win_fill_q, raw_fill_q, slow_fill_q;
  logic [LEN_W-1:0]      cnt_q;
  logic                  pend_q;
  logic [PRICE_BITS-1:0] close_q, hi_q, lo_q, range_q;
  logic [PROD_W-1:0]     prod_q;
  logic [SUM_W-1:0]      sum_q;
  logic [AQ_W-1:0]       avg_num_q;
  logic [LEN_W-1:0]      avg_den_q;
  logic [K_W-1:0]        raw_q, slow_q;
  logic                  flat_q, sv_q;

  logic [LEN_W-1:0]      wl, kl, dl;
  logic [FILL_W-1:0]     win_fill_inc, raw_fill_inc, slow_fill_inc;
  logic                  start;
  logic                  pdiv_done, adiv_done;
  logic [K_W-1:0]        pdiv_quot;
  logic [AQ_W-1:0]       adiv_quot;
  logic [K_W-1:0]        avg_sat;
  logic                  flat;

  function automatic logic [LEN_W-1:0] eff_len(input logic [LEN_W-1:0] v);
    if (v == '0) begin
      return LEN_W'(1);
    end else if (int'(v) > MAX_WINDOW) begin
      return LEN_W'(MAX_WINDOW);
    end
    return v;
  endfunction

  function automatic logic [FILL_W-1:0] sat_inc(input logic [FILL_W-1:0] f);
    return (int'(f) < MAX_WINDOW) ? f + 1'b1 : f;
  endfunction

  function automatic logic [LEN_W-1:0] min_len(input logic [FILL_W-1:0] f,
                                               input logic [LEN_W-1:0] l);
    return (int'(f) < int'(l)) ? LEN_W'(f) : l;
  endfunction

  function automatic logic [PTR_W-1:0] ptr_inc(input logic [PTR_W-1:0] p);
    return (p == PTR_W'(MAX_WINDOW - 1)) ? '0 : p + 1'b1;
  endfunction

  function automatic logic [PTR_W-1:0] ptr_dec(input logic [PTR_W-1:0] p);
    return (p == '0) ? PTR_W'(MAX_WINDOW - 1) : p - 1'b1;
  endfunction

  assign wl            = eff_len(cfg_i.window_len);
  assign kl            = eff_len(cfg_i.smooth_len);
  assign dl            = eff_len(cfg_i.signal_len);
  assign win_fill_inc  = sat_inc(win_fill_q);
  assign raw_fill_inc  = sat_inc(raw_fill_q);
  assign slow_fill_inc = sat_inc(slow_fill_q);
  assign start         = (state_q == ST_IDLE) && !in_empty_i && !out_full_i;
  assign in_pop_o      = start;
  assign out_push_o    = (state_q == ST_OUT);
  assign flat          = (hi_q <= lo_q);
  assign avg_sat       = (adiv_quot > AQ_W'(FULL_SCALE)) ? FULL_SCALE : K_W'(adiv_quot);

  // Window rings and history rings: one write and one registered read a cycle.
  always_ff @(posedge clk_i) begin
    if (start) begin
      high_mem[wp_q] <= high_i;
      low_mem[wp_q]  <= low_i;
    end
    if (state_q == ST_RAWWR) begin
      raw_mem[item_ptr_q] <= raw_q;
    end
    if (state_q == ST_SLOWWR) begin
      slow_mem[slow_ptr_q] <= slow_q;
    end
    high_rd_q <= high_mem[rd_addr_q];
    low_rd_q  <= low_mem[rd_addr_q];
    raw_rd_q  <= raw_mem[rd_addr_q];
    slow_rd_q <= slow_mem[rd_addr_q];
  end

  so_div #(.RW(PRICE_BITS), .QW(K_W)) u_pdiv (
    .clk_i,
    .rst_ni,
    .start_i       (state_q == ST_MUL),
    .init_rem_i    (prod_q[PROD_W-1:K_W]),
    .dividend_lo_i (prod_q[K_W-1:0]),
    .divisor_i     (range_q),
    .done_o        (pdiv_done),
    .quot_o        (pdiv_quot)
  );

  so_div #(.RW(LEN_W), .QW(AQ_W)) u_adiv (
    .clk_i,
    .rst_ni,
    .start_i       ((state_q == ST_KGO) || (state_q == ST_DGO)),
    .init_rem_i    ('0),
    .dividend_lo_i (avg_num_q),
    .divisor_i     (avg_den_q),
    .done_o        (adiv_done),
    .quot_o        (adiv_quot)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      wp_q        <= '0;
      item_ptr_q  <= '0;
      slow_ptr_q  <= '0;
      rd_addr_q   <= '0;
      win_fill_q  <= '0;
      raw_fill_q  <= '0;
      slow_fill_q <= '0;
      cnt_q       <= '0;
      pend_q      <= 1'b0;
      close_q     <= '0;
      hi_q        <= '0;
      lo_q        <= '0;
      range_q     <= '0;
      prod_q      <= '0;
      sum_q       <= '0;
      avg_num_q   <= '0;
      avg_den_q   <= '0;
      raw_q       <= '0;
      slow_q      <= '0;
      flat_q      <= 1'b0;
      sv_q        <= 1'b0;
      res_o       <= '0;
    end else begin
      case (state_q)
        ST_IDLE: begin
          if (start) begin
            close_q    <= close_i;
            item_ptr_q <= wp_q;
            rd_addr_q  <= wp_q;
            wp_q       <= ptr_inc(wp_q);
            win_fill_q <= win_fill_inc;
            cnt_q      <= min_len(win_fill_inc, wl);
            pend_q     <= 1'b0;
            hi_q       <= '0;
            lo_q       <= '1;
            state_q    <= ST_SCAN;
          end
        end
        ST_SCAN: begin
          if (pend_q) begin
            if (high_rd_q > hi_q) begin
              hi_q <= high_rd_q;
            end
            if (low_rd_q < lo_q) begin
              lo_q <= low_rd_q;
            end
          end
          if (cnt_q != '0) begin
            cnt_q     <= cnt_q - 1'b1;
            rd_addr_q <= ptr_dec(rd_addr_q);
            pend_q    <= 1'b1;
          end else begin
            pend_q <= 1'b0;
            if (!pend_q) begin
              state_q <= ST_RATIO;
            end
          end
        end
        ST_RATIO: begin
          flat_q <= flat;
          if (flat || (close_q <= lo_q)) begin
            raw_q   <= '0;
            state_q <= ST_RAWWR;
          end else if (close_q >= hi_q) begin
            raw_q   <= FULL_SCALE;
            state_q <= ST_RAWWR;
          end else begin
            prod_q  <= PROD_W'(close_q - lo_q) * PROD_W'(FULL_SCALE);
            range_q <= hi_q - lo_q;
            state_q <= ST_MUL;
          end
        end
        ST_MUL: begin
          state_q <= ST_DIVR;
        end
        ST_DIVR: begin
          if (pdiv_done) begin
            raw_q   <= pdiv_quot;
            state_q <= ST_RAWWR;
          end
        end
        ST_RAWWR: begin
          raw_fill_q <= raw_fill_inc;
          sv_q       <= (int'(raw_fill_inc) >= int'(kl));
          rd_addr_q  <= item_ptr_q;
          cnt_q      <= min_len(raw_fill_inc, kl);
          pend_q     <= 1'b0;
          sum_q      <= '0;
          if (int'(raw_fill_inc) >= int'(kl)) begin
            state_q <= ST_SUMK;
          end else begin
            res_o   <= '{raw_k: raw_q, slow_k: '0, signal_d: '0, slow_valid: 1'b0,
                         signal_valid: 1'b0, flat_range: flat_q};
            state_q <= ST_OUT;
          end
        end
        ST_SUMK: begin
          if (pend_q) begin
            sum_q <= sum_q + SUM_W'(raw_rd_q);
          end
          if (cnt_q != '0) begin
            cnt_q     <= cnt_q - 1'b1;
            rd_addr_q <= ptr_dec(rd_addr_q);
            pend_q    <= 1'b1;
          end else begin
            pend_q <= 1'b0;
            if (!pend_q) begin
              avg_num_q <= AQ_W'(sum_q) + AQ_W'(kl >> 1);
              avg_den_q <= kl;
              state_q   <= ST_KGO;
            end
          end
        end
        ST_KGO: begin
          state_q <= ST_DIVK;
        end
        ST_DIVK: begin
          if (adiv_done) begin
            slow_q  <= avg_sat;
            state_q <= ST_SLOWWR;
          end
        end
        ST_SLOWWR: begin
          slow_ptr_q  <= ptr_inc(slow_ptr_q);
          slow_fill_q <= slow_fill_inc;
          rd_addr_q   <= slow_ptr_q;
          cnt_q       <= min_len(slow_fill_inc, dl);
          pend_q      <= 1'b0;
          sum_q       <= '0;
          if (int'(slow_fill_inc) >= int'(dl)) begin
            state_q <= ST_SUMD;
          end else begin
            res_o   <= '{raw_k: raw_q, slow_k: slow_q, signal_d: '0, slow_valid: 1'b1,
                         signal_valid: 1'b0, flat_range: flat_q};
            state_q <= ST_OUT;
          end
        end
        ST_SUMD: begin
          if (pend_q) begin
            sum_q <= sum_q + SUM_W'(slow_rd_q);
          end
          if (cnt_q != '0) begin
            cnt_q     <= cnt_q - 1'b1;
            rd_addr_q <= ptr_dec(rd_addr_q);
            pend_q    <= 1'b1;
          end else begin
            pend_q <= 1'b0;
            if (!pend_q) begin
              avg_num_q <= AQ_W'(sum_q) + AQ_W'(dl >> 1);
              avg_den_q <= dl;
              state_q   <= ST_DGO;
            end
          end
        end
        ST_DGO: begin
          state_q <= ST_DIVD;
        end
        ST_DIVD: begin
          if (adiv_done) begin
            res_o   <= '{raw_k: raw_q, slow_k: slow_q, signal_d: avg_sat,
                         slow_valid: sv_q, signal_valid: 1'b1, flat_range: flat_q};
            state_q <= ST_OUT;
          end
        end
        ST_OUT: begin
          state_q <= ST_IDLE;
        end
        default: begin
          state_q <= ST_IDLE;
        end
      endcase
    end
  end

endmodule

// ===== sv/so_checker.sv =====
// Checker on the result ports of the stochastic oscillator, bound to the top.
// Depends on so_pkg and assert_macros.svh.
`include "assert_macros.svh"

module so_props (
  input logic                   clk_i,
  input logic                   rst_ni,
  input logic                   pready,
  input logic                   empty,
  input logic [so_pkg::K_W-1:0] raw_k_o,
  input logic [so_pkg::K_W-1:0] slow_k_o,
  input logic [so_pkg::K_W-1:0] signal_d_o,
  input logic                   slow_valid_o,
  input logic                   signal_valid_o,
  input logic                   flat_range_o
);
  import so_pkg::*;

  `SO_ASSERT(a_raw_range, clk_i, rst_ni, !empty |-> raw_k_o <= FULL_SCALE, "raw K too big")
  `SO_ASSERT(a_flat_zero, clk_i, rst_ni, (!empty && flat_range_o) |-> raw_k_o == '0, "flat raw K")
  `SO_ASSERT(a_valid_order, clk_i, rst_ni, (!empty && signal_valid_o) |-> slow_valid_o, "D before K")
  `SO_ASSERT(a_no_avg, clk_i, rst_ni, (!empty && !slow_valid_o) |-> {slow_k_o, signal_d_o} == '0, "avg")
  `SO_ASSERT_ALWAYS(a_pready, clk_i, pready, "configuration port stalled")

endmodule

bind stochastic_oscillator so_props u_so_props (.*);

// ===== dv/so_checker.sv =====
// Checker of the stochastic oscillator: watches both queue channels and the
// register writes, predicts every result and compares it. Depends on so_pkg.
`timescale 1ns / 100ps

module so_checker (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      psel,
  input  logic                      penable,
  input  logic                      pwrite,
  input  logic                      pready,
  input  logic [so_pkg::ADDR_W-1:0] paddr,
  input  logic [so_pkg::DATA_W-1:0] pwdata,
  input  logic                      push,
  input  logic                      full,
  input  logic [31:0]               high_price_i,
  input  logic [31:0]               low_price_i,
  input  logic [31:0]               close_price_i,
  input  logic                      empty,
  input  logic                      pop,
  input  logic [so_pkg::K_W-1:0]    raw_k_o,
  input  logic [so_pkg::K_W-1:0]    slow_k_o,
  input  logic [so_pkg::K_W-1:0]    signal_d_o,
  input  logic                      slow_valid_o,
  input  logic                      signal_valid_o,
  input  logic                      flat_range_o,
  output int                        fail_count_o,
  output int                        pending_o
);
  import so_pkg::*;

  localparam int DEPTH = 32;

  logic [31:0]    highs [DEPTH];
  logic [31:0]    lows [DEPTH];
  logic [K_W-1:0] raw_ring [DEPTH];
  logic [K_W-1:0] slow_ring [DEPTH];
  int             bar_ptr, bar_fill, raw_fill, slow_ptr, slow_fill;
  cfg_t           cfg;
  res_t           expected_results [$];

  function automatic int clamp_len(logic [LEN_W-1:0] v);
    if (v == 0) return 1;
    if (v > DEPTH) return DEPTH;
    return int'(v);
  endfunction

  // Bit-serial floor(d * 25600 / r) for d < r, without overflow.
  function automatic logic [K_W-1:0] percent_of(logic [31:0] d, logic [31:0] r);
    logic [K_W-1:0] q;
    logic [32:0]    rem;
    q = '0;
    rem = '0;
    for (int b = 14; b >= 0; b--) begin
      q = q << 1;
      if (rem >= r - rem) begin
        q++;
        rem = rem - (r - rem);
      end else begin
        rem = rem + rem;
      end
      if (FULL_SCALE[b]) begin
        if (rem >= r - d) begin
          q++;
          rem = rem - (r - d);
        end else begin
          rem = rem + d;
        end
      end
    end
    return q;
  endfunction

  function automatic logic [K_W-1:0] rounded_mean(int s, int n);
    int v;
    v = (s + n / 2) / n;
    return (v > 25600) ? FULL_SCALE : K_W'(v);
  endfunction

  function automatic res_t predict_bar(logic [31:0] hp, logic [31:0] lp, logic [31:0] cp);
    res_t r;
    logic [31:0] hi, lo;
    int wl, kl, dl, n, s;
    wl = clamp_len(cfg.window_len);
    kl = clamp_len(cfg.smooth_len);
    dl = clamp_len(cfg.signal_len);
    r = '0;
    highs[bar_ptr] = hp;
    lows[bar_ptr] = lp;
    bar_ptr = (bar_ptr + 1) % DEPTH;
    if (bar_fill < DEPTH) bar_fill++;
    hi = '0;
    lo = '1;
    n = (bar_fill < wl) ? bar_fill : wl;
    for (int i = 0; i < n; i++) begin
      if (highs[(bar_ptr + DEPTH - 1 - i) % DEPTH] > hi) hi = highs[(bar_ptr + DEPTH - 1 - i) % DEPTH];
      if (lows[(bar_ptr + DEPTH - 1 - i) % DEPTH] < lo) lo = lows[(bar_ptr + DEPTH - 1 - i) % DEPTH];
    end
    r.flat_range = (hi <= lo);
    if (r.flat_range || cp <= lo) r.raw_k = '0;
    else if (cp >= hi) r.raw_k = FULL_SCALE;
    else r.raw_k = percent_of(cp - lo, hi - lo);
    // The raw ring shares the bar pointer.
    raw_ring[(bar_ptr + DEPTH - 1) % DEPTH] = r.raw_k;
    if (raw_fill < DEPTH) raw_fill++;
    r.slow_valid = (raw_fill >= kl);
    if (r.slow_valid) begin
      s = 0;
      for (int i = 0; i < kl; i++) s += raw_ring[(bar_ptr + DEPTH - 1 - i) % DEPTH];
      r.slow_k = rounded_mean(s, kl);
      slow_ring[slow_ptr] = r.slow_k;
      slow_ptr = (slow_ptr + 1) % DEPTH;
      if (slow_fill < DEPTH) slow_fill++;
      r.signal_valid = (slow_fill >= dl);
      if (r.signal_valid) begin
        s = 0;
        for (int i = 0; i < dl; i++) s += slow_ring[(slow_ptr + DEPTH - 1 - i) % DEPTH];
        r.signal_d = rounded_mean(s, dl);
      end
    end
    return r;
  endfunction

  always_ff @(posedge clk_i or negedge rst_ni) begin
    res_t e;
    if (!rst_ni) begin
      bar_ptr = 0;
      bar_fill = 0;
      raw_fill = 0;
      slow_ptr = 0;
      slow_fill = 0;
      cfg = '{WINDOW_LEN_RST, SMOOTH_LEN_RST, SIGNAL_LEN_RST};
      fail_count_o <= 0;
      expected_results.delete();
      pending_o <= 0;
    end else begin
      if (psel && penable && pwrite && pready) begin
        case (reg_idx_e'(paddr[3:2]))
          REG_WINDOW: cfg.window_len = pwdata[LEN_W-1:0];
          REG_SMOOTH: cfg.smooth_len = pwdata[LEN_W-1:0];
          REG_SIGNAL: cfg.signal_len = pwdata[LEN_W-1:0];
          default: ;
        endcase
      end
      if (pop && !empty) begin
        if (expected_results.size() == 0) begin
          $error("result transaction with no expectation waiting");
          fail_count_o <= fail_count_o + 1;
        end else begin
          e = expected_results.pop_front();
          if (raw_k_o !== e.raw_k || slow_k_o !== e.slow_k || signal_d_o !== e.signal_d ||
              slow_valid_o !== e.slow_valid || signal_valid_o !== e.signal_valid ||
              flat_range_o !== e.flat_range) begin
            fail_count_o <= fail_count_o + 1;
            if (raw_k_o !== e.raw_k)
              $error("raw_k: expected %0d, got %0d", e.raw_k, raw_k_o);
            if (slow_k_o !== e.slow_k)
              $error("slow_k: expected %0d, got %0d", e.slow_k, slow_k_o);
            if (signal_d_o !== e.signal_d)
              $error("signal_d: expected %0d, got %0d", e.signal_d, signal_d_o);
            if (slow_valid_o !== e.slow_valid)
              $error("slow_valid: expected %0d, got %0d", e.slow_valid, slow_valid_o);
            if (signal_valid_o !== e.signal_valid)
              $error("signal_valid: expected %0d, got %0d", e.signal_valid, signal_valid_o);
            if (flat_range_o !== e.flat_range)
              $error("flat_range: expected %0d, got %0d", e.flat_range, flat_range_o);
          end
        end
      end
      if (push && !full)
        expected_results.push_back(predict_bar(high_price_i, low_price_i, close_price_i));
      pending_o <= expected_results.size();
    end
  end

endmodule

// ===== dv/tb.sv =====
// Top of the stochastic oscillator testbench: clock, reset, bar stimulus,
// register writes and the verdict. Depends on so_pkg, so_checker and the RTL.
`timescale 1ns / 100ps

module tb;
  import so_pkg::*;

  logic              clk_i = 1'b0;
  logic              rst_ni = 1'b0;
  logic              psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
  logic [ADDR_W-1:0] paddr = '0;
  logic [DATA_W-1:0] pwdata = '0;
  logic [DATA_W-1:0] prdata;
  logic              pready;
  logic              push = 1'b0, full, empty, pop = 1'b0;
  logic [31:0]       high_price = '0, low_price = '0, close_price = '0;
  logic [K_W-1:0]    raw_k, slow_k, signal_d;
  logic              slow_valid, signal_valid, flat_range;
  int                fail_count, pending;
  // Idle and stall probabilities in percent for the current phase.
  int                send_idle_pct = 0, recv_stall_pct = 0;

  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  stochastic_oscillator DUT (
    .clk_i, .rst_ni, .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready,
    .push, .full,
    .high_price_i(high_price), .low_price_i(low_price), .close_price_i(close_price),
    .empty, .pop,
    .raw_k_o(raw_k), .slow_k_o(slow_k), .signal_d_o(signal_d),
    .slow_valid_o(slow_valid), .signal_valid_o(signal_valid), .flat_range_o(flat_range)
  );

  so_checker u_checker (
    .clk_i, .rst_ni, .psel, .penable, .pwrite, .pready, .paddr, .pwdata,
    .push, .full, .high_price_i(high_price), .low_price_i(low_price),
    .close_price_i(close_price), .empty, .pop,
    .raw_k_o(raw_k), .slow_k_o(slow_k), .signal_d_o(signal_d),
    .slow_valid_o(slow_valid), .signal_valid_o(signal_valid),
    .flat_range_o(flat_range), .fail_count_o(fail_count), .pending_o(pending)
  );

  // The receiver decides afresh at every edge whether to take the oldest result.
  always @(posedge clk_i)
    pop <= rst_ni && ($urandom_range(99) >= recv_stall_pct);

  // One bar transaction: an optional idle gap, then push held until accepted.
  // Push stays high afterwards so that bars can follow back to back; the idle
  // gap or the drain lowers it.
  task automatic send_bar(logic [31:0] hp, logic [31:0] lp, logic [31:0] cp);
    while ($urandom_range(99) < send_idle_pct) begin
      push <= 1'b0;
      @(posedge clk_i);
    end
    push <= 1'b1;
    high_price <= hp;
    low_price <= lp;
    close_price <= cp;
    @(posedge clk_i);
    while (full) @(posedge clk_i);
  endtask

  // A random bar around a drifting level; the odd one has high below low or
  // a close far outside the range, and some use the full 32-bit span.
  task automatic send_random_bar(inout logic [31:0] level);
    logic [31:0] hp, lp, cp, span;
    int          kind;
    kind = $urandom_range(99);
    if (kind < 8) begin
      send_bar($urandom, $urandom, $urandom);
    end else begin
      level = level + $urandom_range(20000) - 10000;
      span = (kind < 15) ? 0 : $urandom_range(kind < 60 ? 4000 : 2000000);
      hp = level + span;
      lp = level - span;
      cp = (kind < 20) ? $urandom : lp + $urandom_range(2 * span);
      send_bar(hp, lp, cp);
    end
  endtask

  // Register write with its setup and access cycles; the block must be idle.
  // The select stays high so that writes can follow back to back.
  task automatic write_reg(reg_idx_e idx, int value);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= ADDR_W'(4 * int'(idx));
    pwdata <= value;
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    while (!pready) @(posedge clk_i);
  endtask

  task automatic wait_drained();
    push <= 1'b0;
    while (pending != 0) @(posedge clk_i);
    // Every accepted bar has had its result taken once pending is zero; the wait adds margin.
    repeat (200) @(posedge clk_i);
  endtask

  task automatic set_lengths(int wl, int kl, int dl);
    wait_drained();
    write_reg(REG_WINDOW, wl);
    write_reg(REG_SMOOTH, kl);
    write_reg(REG_SIGNAL, dl);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
  endtask

  initial begin
    logic [31:0] level;
    int          phase_lens [8][3];
    phase_lens = '{'{14, 3, 3}, '{1, 1, 1}, '{32, 32, 32}, '{0, 0, 0},
                   '{63, 40, 33}, '{5, 7, 2}, '{20, 2, 9}, '{3, 32, 1}};
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed bars at the reset lengths: extremes of every price field, a
    // flat range, an inverted range and closes below, at and above the range.
    send_bar('1, '0, 32'h8000_0000);
    send_bar('1, '0, '1);
    send_bar('1, '0, '0);
    send_bar(32'h5555_5555, 32'hAAAA_AAAA, 32'h5555_5555);
    send_bar(32'h0001_0000, 32'h0001_0000, 32'h0001_0000);
    send_bar(32'h0010_0000, 32'h0020_0000, 32'h0015_0000);
    send_bar(32'h0030_0000, 32'h0010_0000, 32'h0000_1000);
    send_bar(32'h0030_0000, 32'h0010_0000, 32'h0040_0000);
    send_bar(32'h0030_0000, 32'h0010_0000, 32'h0020_0001);
    send_bar(32'hAAAA_AAAA, 32'h5555_5555, 32'h7FFF_FFFF);
    // A flat window at length one.
    set_lengths(1, 1, 1);
    send_bar(32'h1234_0000, 32'h1234_0000, 32'h1234_0000);
    send_bar(32'h1234_0000, 32'h1234_0000, 32'h2000_0000);
    // Changing lengths mid-stream: the new lengths act on the existing fills.
    set_lengths(32, 32, 32);
    for (int i = 0; i < 6; i++) send_bar($urandom, $urandom, $urandom);

    // Random phases across length settings and idling patterns.
    level = 32'h0100_0000;
    for (int p = 0; p < 16; p++) begin
      set_lengths(phase_lens[p % 8][0], phase_lens[p % 8][1], phase_lens[p % 8][2]);
      case (p % 4)
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_idle_pct = 57; recv_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct = 57; end
        default: begin send_idle_pct = 18; recv_stall_pct = 18; end
      endcase
      for (int i = 0; i < 100; i++) send_random_bar(level);
    end
    wait_drained();
    if (fail_count == 0) begin
      $display("tb: clean");
    end else begin
      $display("tb: errors");
    end
    $finish;
  end

  // Time limit for the run of 1600 random bars with stalls, plus the pauses.
  initial begin
    #20ms;
    $display("tb: errors");
    $finish;
  end

endmodule
